@@ sv/aisb_pkg.sv @@
// Package for the AES inverse S-box byte unit: mode codes, the pipeline item type
// and the GF(2^8) helper functions. It has no dependencies.
package aisb_pkg;

  // Low byte of the field polynomial x^8+x^4+x^3+x+1.
  localparam logic [7:0] FieldPolyLow = 8'h1B;
  // Constant added by the inverse affine transform.
  localparam logic [7:0] AffineInvConst = 8'h05;
  // Multiply stages that build a^254 from a^2 and a^4.
  localparam int unsigned NumMulStages = 6;
  // Width of the configuration address (register 0 at byte address 0).
  localparam int unsigned AddrWidth = 3;

  typedef enum logic [1:0] {
    MODE_INV    = 2'd0,
    MODE_AFFINE = 2'd1,
    MODE_SBOX   = 2'd2,
    MODE_BYPASS = 2'd3
  } aisb_mode_e;

  // One item in flight: t is the running product, s the next square power.
  typedef struct packed {
    logic       do_inv;
    logic [7:0] bypass;
    logic [7:0] t;
    logic [7:0] s;
  } aisb_item_t;

  // Field product, reduced modulo the AES polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ FieldPolyLow) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2), so this reduces to an XOR network.
  function automatic logic [7:0] gf_sq(input logic [7:0] a);
    return gf_mul(a, a);
  endfunction

  // Inverse affine transform: rotl 1, 3 and 6, then add the constant.
  function automatic logic [7:0] inv_affine(input logic [7:0] v);
    logic [7:0] r1;
    logic [7:0] r3;
    logic [7:0] r6;
    r1 = {v[6:0], v[7]};
    r3 = {v[4:0], v[7:5]};
    r6 = {v[1:0], v[7:2]};
    return r1 ^ r3 ^ r6 ^ AffineInvConst;
  endfunction

endpackage

@@ sv/aisb_mul_stage.sv @@
// One multiply stage of the field inverse pipeline: t <= t*s, s <= s^2.
// Depends on aisb_pkg for the item type and the field functions.
module aisb_mul_stage import aisb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  aisb_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output aisb_item_t out_item_o
);

  logic       valid_q;
  aisb_item_t item_q;
  aisb_item_t item_d;

  // The stage takes a new item when it is empty or its item leaves this cycle.
  assign in_ready_o = ~valid_q | out_ready_i;

  // One field multiply and one squaring per stage.
  always_comb begin
    item_d        = in_item_i;
    item_d.t      = gf_mul(in_item_i.t, in_item_i.s);
    item_d.s      = gf_sq(in_item_i.s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

@@ sv/aes_inverse_sbox_byte.sv @@
// AES inverse S-box byte unit: field inverse, inverse affine transform, both, or bypass.
// Seven register stages: one select stage and six field-multiply stages that form
// a^254. Throughput is one byte per cycle while the output is not stalled; each stage
// holds its item under back-pressure and frees as soon as it drains.
// Reset clears all valid bits and sets the mode register to field inverse.
// Depends on aisb_pkg and aisb_mul_stage.
module aes_inverse_sbox_byte import aisb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_in
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] data_out
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  aisb_mode_e mode_q;
  logic       cfg_wr;
  logic       sel_reg0;

  logic       stg_valid [NumMulStages+1];
  logic       stg_ready [NumMulStages+1];
  aisb_item_t stg_item  [NumMulStages+1];

  logic       in_valid_q;
  aisb_item_t in_item_q;
  aisb_item_t in_item_d;
  logic [7:0] aff;
  logic [7:0] base;

  // Configuration: one register at word 0, always ready.
  assign pready   = 1'b1;
  assign sel_reg0 = (paddr[AddrWidth-1] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && sel_reg0;
  assign prdata   = sel_reg0 ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INV;
    end else if (cfg_wr) begin
      mode_q <= aisb_mode_e'(pwdata[1:0]);
    end
  end

  // Select stage: apply the affine transform in the affine and S-box modes, and seed a^2 and a^4.
  always_comb begin
    aff  = inv_affine(s_axis_tdata);
    base = ((mode_q == MODE_AFFINE) || (mode_q == MODE_SBOX)) ? aff : s_axis_tdata;
    in_item_d.do_inv = (mode_q == MODE_INV) || (mode_q == MODE_SBOX);
    in_item_d.bypass = base;
    in_item_d.t      = gf_sq(base);
    in_item_d.s      = gf_sq(gf_sq(base));
  end

  assign s_axis_tready = ~in_valid_q | stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_d;
    end
  end

  assign stg_valid[0] = in_valid_q;
  assign stg_item[0]  = in_item_q;

  // Multiply chain: a^6, a^14, a^30, a^62, a^126, a^254.
  for (genvar g = 0; g < NumMulStages; g++) begin : g_mul
    aisb_mul_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[g]),
      .in_ready_o  (stg_ready[g]),
      .in_item_i   (stg_item[g]),
      .out_valid_o (stg_valid[g+1]),
      .out_ready_i (stg_ready[g+1]),
      .out_item_o  (stg_item[g+1])
    );
  end

  // Output: inverse or the selected byte, straight from the last stage.
  assign stg_ready[NumMulStages] = m_axis_tready;
  assign m_axis_tvalid = stg_valid[NumMulStages];
  assign m_axis_tdata  = stg_item[NumMulStages].do_inv ? stg_item[NumMulStages].t
                                                       : stg_item[NumMulStages].bypass;

`ifndef SYNTH
  // An empty select stage always takes a transfer.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty select stage");

  // A select-stage item moves into the first multiply stage when that stage frees.
  a_forward_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && stg_ready[0]) |=> stg_valid[1])
    else $error("item lost between select and multiply stages");

  // The mode changes only on a configuration write.
  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr |=> $stable(mode_q))
    else $error("mode changed without a write transfer");
`endif

endmodule

@@ test/tb_aes_inverse_sbox_byte.sv @@
// Self-checking testbench for the AES inverse S-box byte unit: a directed table, then
// random byte streams under every mode, with bursty input and a stalling receiver.
// Depends on aisb_pkg and the aes_inverse_sbox_byte RTL.
module tb_aes_inverse_sbox_byte;
  import aisb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned NumPhases = 7;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned LongHoldAfter = 400;
  localparam logic [AddrWidth-1:0] ModeAddr = 3'd0;
  localparam logic [AddrWidth-1:0] UnusedAddr = 3'd4;
  localparam logic [7:0] UnaffineConst = 8'h05;

  typedef enum logic {
    STEP_WRITE,
    STEP_ITEM
  } step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [AddrWidth-1:0] addr;
    logic [31:0]          value;
    logic                 known;
    logic [7:0]           want;
  } dir_step_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] data_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [7:0] data_out
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  aisb_mode_e  mode_now;
  logic [7:0]  expected_bytes[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned bytes_accepted;
  int unsigned burst_left;
  logic [7:0]  out_want;

  // Directed steps: expected bytes are typed in where they are well known.
  dir_step_t directed_steps [24] = '{
    '{STEP_ITEM,  ModeAddr,   32'h00, 1'b1, 8'h00},  // zero maps to zero
    '{STEP_ITEM,  ModeAddr,   32'h01, 1'b1, 8'h01},
    '{STEP_ITEM,  ModeAddr,   32'h02, 1'b1, 8'h8D},
    '{STEP_ITEM,  ModeAddr,   32'h53, 1'b1, 8'hCA},
    '{STEP_ITEM,  ModeAddr,   32'hFF, 1'b0, 8'h00},
    '{STEP_WRITE, ModeAddr,   32'h1,  1'b0, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'h00, 1'b1, 8'h05},
    '{STEP_ITEM,  ModeAddr,   32'h63, 1'b1, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'hFF, 1'b0, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'hA5, 1'b0, 8'h00},
    '{STEP_WRITE, ModeAddr,   32'h2,  1'b0, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'h00, 1'b1, 8'h52},
    '{STEP_ITEM,  ModeAddr,   32'h01, 1'b1, 8'h09},
    '{STEP_ITEM,  ModeAddr,   32'hFF, 1'b1, 8'h7D},
    '{STEP_ITEM,  ModeAddr,   32'h63, 1'b1, 8'h00},
    // A write to an unused register index must leave the mode alone.
    '{STEP_WRITE, UnusedAddr, 32'h0,  1'b0, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'h00, 1'b1, 8'h52},
    // Upper bits of the write data are dropped; mode 3 passes data through.
    '{STEP_WRITE, ModeAddr,   32'hFFFF_FFFF, 1'b0, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'h00, 1'b1, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'hFF, 1'b1, 8'hFF},
    '{STEP_ITEM,  ModeAddr,   32'h5A, 1'b1, 8'h5A},
    '{STEP_WRITE, ModeAddr,   32'hFFFF_FFFC, 1'b0, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'h00, 1'b1, 8'h00},
    '{STEP_ITEM,  ModeAddr,   32'hAA, 1'b0, 8'h00}
  };

  aes_inverse_sbox_byte uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Field product modulo x^8+x^4+x^3+x+1, by shift and add.
  function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc ^= sh;
      end
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? 8'h1B : 8'h00);
    end
    return acc;
  endfunction

  // The inverse is a^254, which also sends zero to zero.
  function automatic logic [7:0] field_reciprocal(input logic [7:0] a);
    logic [7:0] acc;
    acc = 8'h01;
    for (int k = 0; k < 254; k++) begin
      acc = field_product(acc, a);
    end
    return acc;
  endfunction

  // Bit i of the result is the XOR of input bits i+2, i+5 and i+7, plus the constant.
  function automatic logic [7:0] unaffine(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[(i + 2) % 8] ^ v[(i + 5) % 8] ^ v[(i + 7) % 8] ^ UnaffineConst[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] inv_sbox_predict(input aisb_mode_e m, input logic [7:0] d);
    case (m)
      MODE_INV:    return field_reciprocal(d);
      MODE_AFFINE: return unaffine(d);
      MODE_SBOX:   return field_reciprocal(unaffine(d));
      default:     return d;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Offer one byte until it is taken; tvalid stays high on return.
  task automatic send_byte(input logic [7:0] d, input logic known, input logic [7:0] want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    expected_bytes = {expected_bytes, (known ? want : inv_sbox_predict(mode_now, d))};
    bytes_accepted++;
    @(negedge clk_i);
  endtask

  // Let every expected byte arrive before touching the mode register.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Setup and access cycle, then read the mode back.
  task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    // The register is decoded by its word address; the byte offset is ignored.
    if (addr[AddrWidth-1:2] == ModeAddr[AddrWidth-1:2]) begin
      mode_now = aisb_mode_e'(value[1:0]);
    end
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = ModeAddr;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== {30'd0, mode_now}) begin
      report_mismatch("mode readback", prdata, {30'd0, mode_now});
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  always #1 clk_i = ~clk_i;

  // Receiver: a rotating stall pattern, stretches of full rate, and one long hold.
  initial begin
    logic [7:0]  stall_pattern;
    int unsigned hold_left;
    int unsigned reload_left;
    logic        long_hold_done;
    stall_pattern  = 8'hFF;
    hold_left      = 0;
    reload_left    = 0;
    long_hold_done = 1'b0;
    m_axis_tready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && bytes_accepted >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (reload_left == 0) begin
        reload_left   = $urandom_range(8, 48);
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      end
      reload_left--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = stall_pattern[0];
      end
    end
  end

  // Check each output transfer against the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected output", {24'd0, m_axis_tdata}, 32'd0);
      end else begin
        out_want = expected_bytes.pop_front();
        if (m_axis_tdata !== out_want) begin
          report_mismatch("data_out", {24'd0, m_axis_tdata}, {24'd0, out_want});
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_aes_inverse_sbox_byte: FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases over all modes.
  initial begin
    logic [31:0] word;
    logic [7:0]  d;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mode_now       = MODE_INV;
    error_count    = 0;
    cycle_count    = 0;
    bytes_accepted = 0;
    burst_left     = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(directed_steps); i++) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        drain();
        write_reg(directed_steps[i].addr, directed_steps[i].value);
      end else begin
        send_byte(directed_steps[i].value[7:0], directed_steps[i].known,
                  directed_steps[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      word = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom & 32'hFFFF_FFFC);
      write_reg(ModeAddr, word | (p % 4));
      if (p % 2 == 1) begin
        write_reg(AddrWidth'($urandom_range(1, (1 << AddrWidth) - 1)), $urandom);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(0, 15))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom);
        endcase
        send_byte(d, 1'b0, 8'h00);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("tb_aes_inverse_sbox_byte: PASS");
    end else begin
      $display("tb_aes_inverse_sbox_byte: FAIL");
    end
    $finish;
  end

endmodule
